// ----- rtl/core/begss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// begss_pkg: shared types and constants for the energy gauge / supply select
// Holds the configuration record, result record, job and state codes, and
// the fixed scaling constants used by the sequencer.
// ----------------------------------------------------------------------------
package begss_pkg;

    // Sample format and energy period
    localparam int ADC_BITS      = 10;
    localparam int TICKS_PER_SUM = 60;
    localparam int TICK_W        = 6;

    // Stream widths
    localparam int IN_TDATA_W  = ((8 * ADC_BITS + 7) / 8) * 8;
    localparam int RESULT_W    = 162;
    localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    // APB port
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_DATA_W = 64;

    // Shared divider geometry
    localparam int DVD_W = 33;
    localparam int DSR_W = 16;
    localparam int DIV_CNT_W = $clog2(DVD_W + 1);

    // Fixed scalings
    localparam int CELL_MUL          = 50;
    localparam int CELL_DIV          = 101;
    localparam int AC_MUL            = 22;
    localparam int AC_DIV            = 100;
    localparam int TENTH_DIV         = 10;
    localparam int POWER_DIV         = 60;
    localparam int ENERGY_DIV        = 60;
    localparam int ENERGY_UNIT       = 1000;
    localparam int CELL_CHARGE_LIMIT = 370;
    localparam logic [15:0] CAL_ZERO_RESULT = 16'hFFFF;

    // Register reset values
    localparam logic [31:0] ONE_PT_RST = 32'h0001_0001;
    localparam logic [63:0] TWO_PT_RST = 64'h0001_0001_0000_0000;

    typedef enum logic [2:0] {
        REG_PACK_CAL   = 3'd0,
        REG_LOWER_CAL  = 3'd1,
        REG_LAMP_CAL   = 3'd2,
        REG_CHG1_CAL   = 3'd3,
        REG_CHG2_CAL   = 3'd4,
        REG_THRESHOLDS = 3'd5,
        REG_SERIES     = 3'd6,
        REG_LAMP_MIN   = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [31:0] pack_cal;
        logic [31:0] lower_cal;
        logic [63:0] lamp_cal;
        logic [63:0] chg1_cal;
        logic [63:0] chg2_cal;
        logic [47:0] thresholds;
        logic        series_pair;
        logic [15:0] lamp_min;
    } cfg_t;

    // Result record, on_mains in bit 0
    typedef struct packed {
        logic [30:0] stored_energy;
        logic        cell_charger_on;
        logic [8:0]  cell_volts;
        logic [7:0]  ac_volts;
        logic [15:0] mains_volts;
        logic [15:0] charge_two_amps;
        logic [15:0] charge_one_amps;
        logic [15:0] lamp_amps;
        logic [15:0] upper_volts;
        logic [15:0] lower_volts;
        logic [15:0] pack_volts;
        logic        on_mains;
    } result_t;

    // One job = one multiply (or two) followed by one divider pass
    typedef enum logic [3:0] {
        JOB_CELL     = 4'd0,
        JOB_AC       = 4'd1,
        JOB_MAINS    = 4'd2,
        JOB_PACK     = 4'd3,
        JOB_LOWER    = 4'd4,
        JOB_LAMP     = 4'd5,
        JOB_CHG1     = 4'd6,
        JOB_CHG2     = 4'd7,
        JOB_VOLT10   = 4'd8,
        JOB_CHG2_10  = 4'd9,
        JOB_PWR_CHG  = 4'd10,
        JOB_LAMP10   = 4'd11,
        JOB_PWR_LAMP = 4'd12,
        JOB_MINUTE   = 4'd13,
        JOB_ETH      = 4'd14
    } job_t;

    localparam int NUM_JOBS = 15;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_ACC,
        ST_FINAL
    } seq_state_t;

endpackage

// ----- rtl/core/begss_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// begss_cfg: APB configuration registers
// Eight registers at 8-byte spacing, written in the APB access cycle and
// read back combinationally.
// ----------------------------------------------------------------------------
module begss_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [begss_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [begss_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [begss_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                               pready,
    output begss_pkg::cfg_t                    cfg
);

    begss_pkg::cfg_t     cfg_reg;
    begss_pkg::cfg_reg_t reg_idx;
    logic                wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = begss_pkg::cfg_reg_t'(paddr[5:3]);
    assign cfg     = cfg_reg;

    // Register writes, masked to width
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pack_cal    <= begss_pkg::ONE_PT_RST;
            cfg_reg.lower_cal   <= begss_pkg::ONE_PT_RST;
            cfg_reg.lamp_cal    <= begss_pkg::TWO_PT_RST;
            cfg_reg.chg1_cal    <= begss_pkg::TWO_PT_RST;
            cfg_reg.chg2_cal    <= begss_pkg::TWO_PT_RST;
            cfg_reg.thresholds  <= '0;
            cfg_reg.series_pair <= 1'b0;
            cfg_reg.lamp_min    <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                begss_pkg::REG_PACK_CAL:   cfg_reg.pack_cal    <= pwdata[31:0];
                begss_pkg::REG_LOWER_CAL:  cfg_reg.lower_cal   <= pwdata[31:0];
                begss_pkg::REG_LAMP_CAL:   cfg_reg.lamp_cal    <= pwdata;
                begss_pkg::REG_CHG1_CAL:   cfg_reg.chg1_cal    <= pwdata;
                begss_pkg::REG_CHG2_CAL:   cfg_reg.chg2_cal    <= pwdata;
                begss_pkg::REG_THRESHOLDS: cfg_reg.thresholds  <= pwdata[47:0];
                begss_pkg::REG_SERIES:     cfg_reg.series_pair <= pwdata[0];
                begss_pkg::REG_LAMP_MIN:   cfg_reg.lamp_min    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        prdata = '0;
        case (reg_idx)
            begss_pkg::REG_PACK_CAL:   prdata = 64'(cfg_reg.pack_cal);
            begss_pkg::REG_LOWER_CAL:  prdata = 64'(cfg_reg.lower_cal);
            begss_pkg::REG_LAMP_CAL:   prdata = cfg_reg.lamp_cal;
            begss_pkg::REG_CHG1_CAL:   prdata = cfg_reg.chg1_cal;
            begss_pkg::REG_CHG2_CAL:   prdata = cfg_reg.chg2_cal;
            begss_pkg::REG_THRESHOLDS: prdata = 64'(cfg_reg.thresholds);
            begss_pkg::REG_SERIES:     prdata = 64'(cfg_reg.series_pair);
            begss_pkg::REG_LAMP_MIN:   prdata = 64'(cfg_reg.lamp_min);
            default:                   prdata = '0;
        endcase
    end

endmodule

// ----- rtl/core/begss_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// begss_divider: shared restoring divider
// Unsigned 33-bit by 16-bit division, one quotient bit per cycle. done
// pulses for one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
module begss_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [begss_pkg::DVD_W-1:0]   dividend,
    input  logic [begss_pkg::DSR_W-1:0]   divisor,
    output logic                          done,
    output logic [begss_pkg::DVD_W-1:0]   quotient
);

    logic [begss_pkg::DVD_W-1:0]     quo_reg;
    logic [begss_pkg::DSR_W-1:0]     rem_reg;
    logic [begss_pkg::DSR_W-1:0]     dsr_reg;
    logic [begss_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                            run_reg;
    logic                            done_reg;

    logic [begss_pkg::DSR_W:0] trial;
    logic [begss_pkg::DSR_W:0] diff;
    logic                      fits;

    // One restoring step
    assign trial = {rem_reg, quo_reg[begss_pkg::DVD_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= run_reg && (cnt_reg == begss_pkg::DIV_CNT_W'(1));
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= begss_pkg::DIV_CNT_W'(begss_pkg::DVD_W);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == begss_pkg::DIV_CNT_W'(1)) begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (run_reg) begin
            quo_reg <= {quo_reg[begss_pkg::DVD_W-2:0], fits};
            rem_reg <= fits ? diff[begss_pkg::DSR_W-1:0] : trial[begss_pkg::DSR_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/core/begss_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// begss_seq: job sequencer with shared multiplier and divider
// Walks fifteen multiply/divide jobs per item, then updates the minute and
// battery energy and chooses the supply.
// ----------------------------------------------------------------------------
module begss_seq (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  begss_pkg::cfg_t                     cfg,
    input  logic                                in_valid,
    input  logic [begss_pkg::IN_TDATA_W-1:0]    in_data,
    output logic                                in_ready,
    input  logic                                out_free,
    output logic                                res_load,
    output begss_pkg::result_t                  res
);

    localparam int AB = begss_pkg::ADC_BITS;

    begss_pkg::seq_state_t state_reg, state_next;
    begss_pkg::job_t       job_reg, job_next;

    logic [AB-1:0]                 smp_reg [0:7];
    logic [31:0]                   slot_reg [0:begss_pkg::NUM_JOBS-1];
    logic [begss_pkg::DVD_W-1:0]   prod_reg, prod_next;
    logic signed [31:0]            me_reg;
    logic [begss_pkg::TICK_W-1:0]  tick_reg;
    logic                          wrap_reg;
    logic [30:0]                   be_reg;
    logic                          mains_reg;

    logic store_en, div_start, acc_load, fin_load, smp_load;

    // Two-point calibration operands
    logic [63:0]   tp_cal;
    logic [AB-1:0] tp_smp;
    logic [15:0]   tp_x1, tp_y1, tp_dy, tp_dx, tp_d;

    // Job operands
    logic [15:0] mul_a1, mul_b1, mul_a, mul_b, dsr;
    logic        two_pt, cal_chk;
    logic [31:0] mul_prod;
    logic [31:0] me_mag;

    logic                        div_done;
    logic [begss_pkg::DVD_W-1:0] div_quo;
    logic [31:0]                 slot_val;

    // Accumulate step
    logic [31:0]        pl_sel;
    logic               lamp_on;
    logic signed [33:0] acc_sum;
    logic signed [31:0] me_sat;
    logic [begss_pkg::TICK_W-1:0] tick_inc;
    logic               wrap;

    // Final step
    logic [33:0] q_sgn, eb_sum;
    logic [30:0] be_upd, be_final;
    logic [15:0] packv, lowv, upv, lo_th, chg_th;
    logic        energy_full, mains_new, series_low;

    // Two-point operand select
    always_comb begin
        tp_cal = cfg.lamp_cal;
        tp_smp = smp_reg[5];
        case (job_reg)
            begss_pkg::JOB_CHG1: begin
                tp_cal = cfg.chg1_cal;
                tp_smp = smp_reg[6];
            end
            begss_pkg::JOB_CHG2: begin
                tp_cal = cfg.chg2_cal;
                tp_smp = smp_reg[7];
            end
            default: ;
        endcase
    end

    assign tp_x1 = tp_cal[15:0];
    assign tp_y1 = tp_cal[31:16];
    assign tp_dy = tp_cal[63:48] - tp_cal[31:16];
    assign tp_dx = tp_cal[47:32] - tp_cal[15:0];
    assign tp_d  = (16'(tp_smp) > tp_x1) ? (16'(tp_smp) - tp_x1) : 16'd0;

    // Per-job operand table
    always_comb begin
        mul_a1  = '0;
        mul_b1  = '0;
        dsr     = 16'd1;
        two_pt  = 1'b0;
        cal_chk = 1'b0;
        case (job_reg)
            begss_pkg::JOB_CELL: begin
                mul_a1 = 16'(smp_reg[0]);
                mul_b1 = 16'(begss_pkg::CELL_MUL);
                dsr    = 16'(begss_pkg::CELL_DIV);
            end
            begss_pkg::JOB_AC: begin
                mul_a1 = 16'(smp_reg[1]);
                mul_b1 = 16'(begss_pkg::AC_MUL);
                dsr    = 16'(begss_pkg::AC_DIV);
            end
            begss_pkg::JOB_MAINS: begin
                mul_a1  = 16'(smp_reg[2]);
                mul_b1  = cfg.pack_cal[31:16];
                dsr     = cfg.pack_cal[15:0];
                cal_chk = 1'b1;
            end
            begss_pkg::JOB_PACK: begin
                mul_a1  = 16'(smp_reg[3]);
                mul_b1  = cfg.pack_cal[31:16];
                dsr     = cfg.pack_cal[15:0];
                cal_chk = 1'b1;
            end
            begss_pkg::JOB_LOWER: begin
                mul_a1  = 16'(smp_reg[4]);
                mul_b1  = cfg.lower_cal[31:16];
                dsr     = cfg.lower_cal[15:0];
                cal_chk = 1'b1;
            end
            begss_pkg::JOB_LAMP, begss_pkg::JOB_CHG1, begss_pkg::JOB_CHG2: begin
                mul_a1  = tp_d;
                mul_b1  = tp_dy;
                dsr     = tp_dx;
                two_pt  = 1'b1;
                cal_chk = 1'b1;
            end
            begss_pkg::JOB_VOLT10: begin
                mul_a1 = slot_reg[begss_pkg::JOB_PACK][15:0];
                mul_b1 = 16'd1;
                dsr    = 16'(begss_pkg::TENTH_DIV);
            end
            begss_pkg::JOB_CHG2_10: begin
                mul_a1 = slot_reg[begss_pkg::JOB_CHG2][15:0];
                mul_b1 = 16'd1;
                dsr    = 16'(begss_pkg::TENTH_DIV);
            end
            begss_pkg::JOB_PWR_CHG: begin
                mul_a1 = slot_reg[begss_pkg::JOB_VOLT10][15:0];
                mul_b1 = slot_reg[begss_pkg::JOB_CHG2_10][15:0];
                dsr    = 16'(begss_pkg::POWER_DIV);
            end
            begss_pkg::JOB_LAMP10: begin
                mul_a1 = slot_reg[begss_pkg::JOB_LAMP][15:0];
                mul_b1 = 16'd1;
                dsr    = 16'(begss_pkg::TENTH_DIV);
            end
            begss_pkg::JOB_PWR_LAMP: begin
                mul_a1 = slot_reg[begss_pkg::JOB_VOLT10][15:0];
                mul_b1 = slot_reg[begss_pkg::JOB_LAMP10][15:0];
                dsr    = 16'(begss_pkg::POWER_DIV);
            end
            begss_pkg::JOB_MINUTE: begin
                dsr = 16'(begss_pkg::ENERGY_DIV);
            end
            begss_pkg::JOB_ETH: begin
                mul_a1 = cfg.thresholds[47:32];
                mul_b1 = 16'(begss_pkg::ENERGY_UNIT);
                dsr    = 16'd1;
            end
            default: ;
        endcase
    end

    // Shared multiplier; second pass adds y1*dx for two-point jobs
    assign mul_a    = (state_reg == begss_pkg::ST_MUL2) ? tp_y1 : mul_a1;
    assign mul_b    = (state_reg == begss_pkg::ST_MUL2) ? tp_dx : mul_b1;
    assign mul_prod = 32'(mul_a) * 32'(mul_b);
    assign me_mag   = me_reg[31] ? (~me_reg + 32'd1) : me_reg;

    begss_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (dsr),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Zero divisor on a calibration gives full scale
    always_comb begin
        if (cal_chk && dsr == 16'd0) begin
            slot_val = 32'(begss_pkg::CAL_ZERO_RESULT);
        end else if (cal_chk) begin
            slot_val = 32'(div_quo[15:0]);
        end else begin
            slot_val = div_quo[31:0];
        end
    end

    // Minute accumulation with saturation
    assign lamp_on = !mains_reg && (slot_reg[begss_pkg::JOB_LAMP][15:0] > cfg.lamp_min);
    assign pl_sel  = lamp_on ? slot_reg[begss_pkg::JOB_PWR_LAMP] : 32'd0;
    assign acc_sum = {{2{me_reg[31]}}, me_reg} + {2'b00, slot_reg[begss_pkg::JOB_PWR_CHG]}
                     - {2'b00, pl_sel};
    always_comb begin
        if (!acc_sum[33] && acc_sum[32:31] != 2'b00) begin
            me_sat = 32'sh7FFF_FFFF;
        end else if (acc_sum[33] && acc_sum[32:31] != 2'b11) begin
            me_sat = 32'sh8000_0000;
        end else begin
            me_sat = acc_sum[31:0];
        end
    end
    assign tick_inc = tick_reg + 1'b1;
    assign wrap     = tick_inc >= begss_pkg::TICK_W'(begss_pkg::TICKS_PER_SUM);

    // Battery energy update, clamped to [0, 2^31-1]
    assign q_sgn  = me_reg[31] ? (34'd0 - 34'(slot_reg[begss_pkg::JOB_MINUTE]))
                               : 34'(slot_reg[begss_pkg::JOB_MINUTE]);
    assign eb_sum = 34'(be_reg) + q_sgn;
    always_comb begin
        if (!wrap_reg) begin
            be_upd = be_reg;
        end else if (eb_sum[33]) begin
            be_upd = '0;
        end else if (eb_sum[32:31] != 2'b00) begin
            be_upd = '1;
        end else begin
            be_upd = eb_sum[30:0];
        end
    end

    // Supply selection with hysteresis
    assign packv       = slot_reg[begss_pkg::JOB_PACK][15:0];
    assign lowv        = slot_reg[begss_pkg::JOB_LOWER][15:0];
    assign upv         = (packv > lowv) ? (packv - lowv) : 16'd0;
    assign lo_th       = cfg.thresholds[15:0];
    assign chg_th      = cfg.thresholds[31:16];
    assign energy_full = 33'(be_upd) >= (33'(slot_reg[begss_pkg::JOB_ETH])
                                         + 33'(begss_pkg::ENERGY_UNIT));
    assign series_low  = cfg.series_pair && (lowv < lo_th || upv < lo_th);
    always_comb begin
        mains_new = mains_reg;
        if (cfg.series_pair) begin
            if (series_low) begin
                mains_new = 1'b1;
            end else if (energy_full || (lowv > chg_th && upv > chg_th)) begin
                mains_new = 1'b0;
            end
        end else begin
            if (upv < lo_th) begin
                mains_new = 1'b1;
            end else if (energy_full || upv > chg_th) begin
                mains_new = 1'b0;
            end
        end
    end
    assign be_final = series_low ? 31'd0 : be_upd;

    // Result record
    always_comb begin
        res.on_mains        = mains_new;
        res.pack_volts      = packv;
        res.lower_volts     = lowv;
        res.upper_volts     = upv;
        res.lamp_amps       = slot_reg[begss_pkg::JOB_LAMP][15:0];
        res.charge_one_amps = slot_reg[begss_pkg::JOB_CHG1][15:0];
        res.charge_two_amps = slot_reg[begss_pkg::JOB_CHG2][15:0];
        res.mains_volts     = slot_reg[begss_pkg::JOB_MAINS][15:0];
        res.ac_volts        = slot_reg[begss_pkg::JOB_AC][7:0];
        res.cell_volts      = slot_reg[begss_pkg::JOB_CELL][8:0];
        res.cell_charger_on = slot_reg[begss_pkg::JOB_CELL][8:0]
                              < 9'(begss_pkg::CELL_CHARGE_LIMIT);
        res.stored_energy   = be_final;
    end

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        job_next   = job_reg;
        prod_next  = prod_reg;
        store_en   = 1'b0;
        div_start  = 1'b0;
        acc_load   = 1'b0;
        fin_load   = 1'b0;
        smp_load   = 1'b0;
        in_ready   = 1'b0;
        res_load   = 1'b0;
        case (state_reg)
            begss_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    smp_load   = 1'b1;
                    job_next   = begss_pkg::JOB_CELL;
                    state_next = begss_pkg::ST_MUL1;
                end
            end
            begss_pkg::ST_MUL1: begin
                if (job_reg == begss_pkg::JOB_MINUTE) begin
                    prod_next = begss_pkg::DVD_W'(me_mag);
                end else begin
                    prod_next = begss_pkg::DVD_W'(mul_prod);
                end
                state_next = two_pt ? begss_pkg::ST_MUL2 : begss_pkg::ST_DIV_START;
            end
            begss_pkg::ST_MUL2: begin
                prod_next  = prod_reg + begss_pkg::DVD_W'(mul_prod);
                state_next = begss_pkg::ST_DIV_START;
            end
            begss_pkg::ST_DIV_START: begin
                div_start  = 1'b1;
                state_next = begss_pkg::ST_DIV_WAIT;
            end
            begss_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    store_en = 1'b1;
                    if (job_reg == begss_pkg::JOB_PWR_LAMP) begin
                        state_next = begss_pkg::ST_ACC;
                    end else if (job_reg == begss_pkg::JOB_ETH) begin
                        state_next = begss_pkg::ST_FINAL;
                    end else begin
                        job_next   = begss_pkg::job_t'(job_reg + 4'd1);
                        state_next = begss_pkg::ST_MUL1;
                    end
                end
            end
            begss_pkg::ST_ACC: begin
                acc_load   = 1'b1;
                job_next   = begss_pkg::JOB_MINUTE;
                state_next = begss_pkg::ST_MUL1;
            end
            begss_pkg::ST_FINAL: begin
                if (out_free) begin
                    fin_load   = 1'b1;
                    res_load   = 1'b1;
                    state_next = begss_pkg::ST_IDLE;
                end
            end
            default: state_next = begss_pkg::ST_IDLE;
        endcase
    end

    // Control and gauge state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= begss_pkg::ST_IDLE;
            job_reg   <= begss_pkg::JOB_CELL;
            me_reg    <= '0;
            tick_reg  <= '0;
            wrap_reg  <= 1'b0;
            be_reg    <= '0;
            mains_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            job_reg   <= job_next;
            if (acc_load) begin
                me_reg   <= me_sat;
                tick_reg <= wrap ? '0 : tick_inc;
                wrap_reg <= wrap;
            end
            if (fin_load) begin
                if (wrap_reg) begin
                    me_reg <= '0;
                end
                be_reg    <= be_final;
                mains_reg <= mains_new;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (smp_load) begin
            for (int i = 0; i < 8; i++) begin
                smp_reg[i] <= in_data[i*AB +: AB];
            end
        end
        if (store_en) begin
            slot_reg[job_reg] <= slot_val;
        end
    end

endmodule

// ----- rtl/core/battery_energy_gauge_supply_select_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_energy_gauge_supply_select_unit: energy gauge and supply selector
// Each item runs fifteen jobs in turn; each job takes a multiplier step (a
//   second for two-point jobs), a divider start and a divider pass and store,
//   with one accumulate step and one final step besides.
// Items pass one at a time through the shared multiplier and divider.
// The next item is taken while the previous result waits in the output reg.
// Reset: synchronous active-low aresetn clears energy, tick count, supply
//   choice and loads the identity calibrations.
// ----------------------------------------------------------------------------
module battery_energy_gauge_supply_select_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // APB configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [begss_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [begss_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [begss_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                 pready,
    // Sample items
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // tdata: cell, ac, mains, pack, lower, lamp, charge_one, charge_two samples
    input  logic [begss_pkg::IN_TDATA_W-1:0]     s_tdata,
    // Result items
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // tdata: on_mains, pack_volts, lower_volts, upper_volts, lamp_amps,
    //        charge_one_amps, charge_two_amps, mains_volts, ac_volts,
    //        cell_volts, cell_charger_on, stored_energy, zero pad
    output logic [begss_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    begss_pkg::cfg_t    cfg;
    begss_pkg::result_t res;
    logic               res_load;
    logic               out_free;
    logic               m_tvalid_reg;
    begss_pkg::result_t m_res_reg;

    begss_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign out_free = !m_tvalid_reg || m_tready;

    begss_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .in_valid (s_tvalid),
        .in_data  (s_tdata),
        .in_ready (s_tready),
        .out_free (out_free),
        .res_load (res_load),
        .res      (res)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = begss_pkg::OUT_TDATA_W'(m_res_reg);

endmodule

// ----- rtl/core/begss_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// begss_checker: port-level checks for the energy gauge
// Watches the stream ports and the consistency of derived result fields.
// ----------------------------------------------------------------------------
module begss_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [begss_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    // Result held until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    // One item at a time: busy right after accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while item in flight");

    // Charger flag tracks cell voltage
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[130] == (m_tdata[129:121] < 9'd370)))
        else $error("cell charger flag mismatch");

    // Upper voltage is pack minus lower, floored
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[48:33] ==
            ((m_tdata[16:1] > m_tdata[32:17]) ? (m_tdata[16:1] - m_tdata[32:17]) : 16'd0)))
        else $error("upper voltage mismatch");

endmodule

bind battery_energy_gauge_supply_select_unit begss_checker u_begss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
